// ===== sv/cyclic_sequence_interner_macros.svh =====
// Assertion macros used by the interner top level.
`ifndef CYCLIC_SEQUENCE_INTERNER_MACROS_SVH
`define CYCLIC_SEQUENCE_INTERNER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/csi_pkg.sv =====
// Types and codes shared by the cyclic sequence interner modules.
`default_nettype none
package csi_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_PREP    = 4'b0010,
    S_ROTATE  = 4'b0100,
    S_SEARCH  = 4'b1000
  } state_t;

  typedef struct packed {
    logic take;
    logic rotate;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/cyclic_sequence_interner.sv =====
// Top level of the cyclic sequence interner.
// Vertices are taken one per cycle, while the collect state holds and no result beat waits
// untaken, into two rings of cells, one in arrival order and one reversed, while the
// smallest vertex is tracked. After the final beat both rings rotate until they start at
// that vertex, the winding is chosen, and the key table RAM, which has registered read
// data, is walked one stored key per cycle. A hit ends the walk early, and error lists
// offer their result on the cycle after their final beat. A result beat that is not taken
// holds off the input. The table is emptied at reset by clearing its entry count, so no
// clearing pass is needed.
`default_nettype none
`include "cyclic_sequence_interner_macros.svh"
module cyclic_sequence_interner #(
  parameter int MAX_LEN     = 16,
  parameter int TABLE_DEPTH = 64,
  parameter int VERTEX_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_vertex,
  input  wire logic       in_last_vertex,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [5:0] out_hull_id,
  output logic            out_was_new,
  output logic      [1:0] out_status
);

  localparam int VB  = VERTEX_BITS;
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int IW  = $clog2(MAX_LEN);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int UW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = MAX_LEN * VB + LW;

  csi_pkg::state_t st_r, st_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [VB-1:0] min_r, min_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [IW-1:0] rotf_r, rotf_nxt, rotr_r, rotr_nxt;
  logic          krev_r, krev_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          ov_r, ov_nxt;
  logic [5:0]    oid_r, oid_nxt;
  logic          onew_r, onew_nxt;
  logic [1:0]    ost_r, ost_nxt;

  logic [VB-1:0] vtx;
  logic [VB-1:0] fq [MAX_LEN];
  logic [VB-1:0] rq [MAX_LEN];
  logic [VB-1:0] key [MAX_LEN];
  logic          push, room, row_hit, last_cmp, we;
  logic [RW-1:0] rdata, wdata;
  logic [AW-1:0] waddr;
  logic [LW-1:0] n_plus;

  always_comb begin
    vtx = '0;
    for (int b = 0; b < VB; b++) begin
      if (b < 8) begin
        vtx[b] = in_vertex[b];
      end
    end
  end

  assign in_ready = (st_r == csi_pkg::S_COLLECT) && (!ov_r || out_ready);
  assign push     = in_valid && in_ready;
  assign room     = (len_r < LW'(MAX_LEN));
  assign n_plus   = len_r + LW'(1);

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cells
    csi_pkg::cell_ctrl_t fc, rc;
    logic tail;
    logic [VB-1:0] nf, nr, ir;
    assign tail = (LW'(i) + LW'(1) == len_r);
    if (i == MAX_LEN - 1) begin : g_end
      assign nf = fq[0];
      assign nr = rq[0];
    end else begin : g_mid
      assign nf = tail ? fq[0] : fq[i+1];
      assign nr = tail ? rq[0] : rq[i+1];
    end
    if (i == 0) begin : g_first
      assign ir = vtx;
    end else begin : g_rest
      assign ir = rq[i-1];
    end
    assign fc.take   = push && room && (len_r == LW'(i));
    assign fc.rotate = (st_r == csi_pkg::S_ROTATE) && (rotf_r != '0);
    assign rc.take   = push && room;
    assign rc.rotate = (st_r == csi_pkg::S_ROTATE) && (rotr_r != '0);
    csi_cell #(.W(VB)) u_fcell (.clk(clk), .ctrl(fc), .ins_data(vtx), .next_data(nf),
                                .q(fq[i]));
    csi_cell #(.W(VB)) u_rcell (.clk(clk), .ctrl(rc), .ins_data(ir), .next_data(nr),
                                .q(rq[i]));
  end

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      key[i] = krev_r ? rq[i] : fq[i];
      wdata[i*VB +: VB] = key[i];
    end
    wdata[RW-1 -: LW] = len_r;
    row_hit = pend_r && (rdata[RW-1 -: LW] == len_r);
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((LW'(i) < len_r) && (rdata[i*VB +: VB] != key[i])) begin
        row_hit = 1'b0;
      end
    end
  end

  assign last_cmp = pend_r && ((UW'(pidx_r) + UW'(1)) == used_r);
  assign waddr    = used_r[AW-1:0];

  function automatic logic [5:0] id6(input logic [AW-1:0] id);
    logic [5:0] r;
    r = '0;
    for (int b = 0; b < 6; b++) begin
      if (b < AW) begin
        r[b] = id[b];
      end
    end
    return r;
  endfunction

  always_comb begin
    st_nxt    = st_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    min_nxt   = min_r;
    start_nxt = start_r;
    rotf_nxt  = rotf_r;
    rotr_nxt  = rotr_r;
    krev_nxt  = krev_r;
    used_nxt  = used_r;
    issue_nxt = issue_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    ov_nxt    = ov_r && !out_ready;
    oid_nxt   = oid_r;
    onew_nxt  = onew_r;
    ost_nxt   = ost_r;
    we        = 1'b0;
    case (st_r)
      csi_pkg::S_COLLECT: begin
        if (push) begin
          if (room) begin
            len_nxt = n_plus;
            if ((len_r == '0) || (vtx < min_r)) begin
              min_nxt   = vtx;
              start_nxt = len_r[IW-1:0];
            end
          end
          if (in_last_vertex) begin
            if (ovf_r || !room) begin
              ov_nxt = 1'b1; oid_nxt = '0; onew_nxt = 1'b0; ost_nxt = csi_pkg::ST_LONG;
              len_nxt = '0; ovf_nxt = 1'b0;
            end else if (n_plus < LW'(3)) begin
              ov_nxt = 1'b1; oid_nxt = '0; onew_nxt = 1'b0; ost_nxt = csi_pkg::ST_SHORT;
              len_nxt = '0; ovf_nxt = 1'b0;
            end else begin
              st_nxt = csi_pkg::S_PREP;
            end
          end else if (!room) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      csi_pkg::S_PREP: begin
        rotf_nxt = start_r;
        rotr_nxt = IW'(len_r - LW'(1) - LW'(start_r));
        st_nxt   = csi_pkg::S_ROTATE;
      end
      csi_pkg::S_ROTATE: begin
        if (rotf_r != '0) begin
          rotf_nxt = rotf_r - IW'(1);
        end
        if (rotr_r != '0) begin
          rotr_nxt = rotr_r - IW'(1);
        end
        if ((rotf_r == '0) && (rotr_r == '0)) begin
          krev_nxt  = (fq[1] > rq[1]);
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          st_nxt    = csi_pkg::S_SEARCH;
        end
      end
      csi_pkg::S_SEARCH: begin
        if (issue_r < used_r) begin
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[AW-1:0];
          issue_nxt = issue_r + UW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (row_hit) begin
          ov_nxt = 1'b1; oid_nxt = id6(pidx_r); onew_nxt = 1'b0; ost_nxt = csi_pkg::ST_OK;
          st_nxt = csi_pkg::S_COLLECT; len_nxt = '0; pend_nxt = 1'b0;
        end else if ((used_r == '0) || last_cmp) begin
          ov_nxt = 1'b1;
          if (used_r == UW'(TABLE_DEPTH)) begin
            oid_nxt = '0; onew_nxt = 1'b0; ost_nxt = csi_pkg::ST_FULL;
          end else begin
            we = 1'b1; used_nxt = used_r + UW'(1);
            oid_nxt = id6(waddr); onew_nxt = 1'b1; ost_nxt = csi_pkg::ST_OK;
          end
          st_nxt = csi_pkg::S_COLLECT; len_nxt = '0; pend_nxt = 1'b0;
        end
      end
      default: st_nxt = csi_pkg::S_COLLECT;
    endcase
  end

  csi_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(issue_r[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= csi_pkg::S_COLLECT;
      len_r  <= '0;
      ovf_r  <= 1'b0;
      used_r <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      used_r <= used_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r   <= min_nxt;
    start_r <= start_nxt;
    rotf_r  <= rotf_nxt;
    rotr_r  <= rotr_nxt;
    krev_r  <= krev_nxt;
    issue_r <= issue_nxt;
    pidx_r  <= pidx_nxt;
    oid_r   <= oid_nxt;
    onew_r  <= onew_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_valid   = ov_r;
  assign out_hull_id = oid_r;
  assign out_was_new = onew_r;
  assign out_status  = ost_r;

  `CSI_ASSERT_IMPL(a_used_bound, 1'b1, used_r <= UW'(TABLE_DEPTH), "entry count overrun")
  `CSI_ASSERT_IMPL(a_err_zero, ov_r && (ost_r != csi_pkg::ST_OK), (oid_r == '0) && !onew_r,
                   "error beat carries an id")
  `CSI_ASSERT_NEXT(a_write_count, we, used_r == $past(used_r) + UW'(1),
                   "append without count step")
  `CSI_ASSERT_IMPL(a_search_free, st_r == csi_pkg::S_SEARCH, !ov_r,
                   "search while a result is pending")

endmodule
`default_nettype wire

// ===== sv/csi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/csi_cell.sv =====
// One vertex cell of the list ring: loads a vertex or takes its neighbour's.
`default_nettype none
module csi_cell #(
  parameter int W = 8
) (
  input  wire logic                clk,
  input  wire csi_pkg::cell_ctrl_t ctrl,
  input  wire logic [W-1:0]        ins_data,
  input  wire logic [W-1:0]        next_data,
  output logic      [W-1:0]        q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      q_r <= ins_data;
    end else if (ctrl.rotate) begin
      q_r <= next_data;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the cyclic sequence interner: lists in, hull ids checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int MAX_LEN = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [5:0]       hull_id;
    logic             was_new;
    csi_pkg::status_t status;
  } hull_result_t;

  class hull_scoreboard;
    logic [7:0]   pending[$];
    bit           too_long;
    logic [7:0]   keys[TABLE_DEPTH][MAX_LEN];
    int           key_len[TABLE_DEPTH];
    int           n_keys;
    hull_result_t awaited[$];
    int           errors;
    int           n_results;

    function void note_vertex(logic [7:0] v, logic last);
      hull_result_t r;
      logic [7:0] key[MAX_LEN];
      logic [7:0] t;
      int n, start, a, b, id;
      bit hit;
      if (pending.size() < MAX_LEN) pending = {pending, v};
      else too_long = 1'b1;
      if (!last) return;
      n = pending.size();
      r.hull_id = '0;
      r.was_new = 1'b0;
      r.status = csi_pkg::ST_OK;
      if (too_long) begin
        r.status = csi_pkg::ST_LONG;
      end else if (n < 3) begin
        r.status = csi_pkg::ST_SHORT;
      end else begin
        start = 0;
        for (int i = 1; i < n; i++) if (pending[i] < pending[start]) start = i;
        for (int i = 0; i < n; i++) key[i] = pending[(start + i) % n];
        if (key[1] > key[n - 1]) begin
          a = 1;
          b = n - 1;
          while (a < b) begin
            t = key[a]; key[a] = key[b]; key[b] = t;
            a++; b--;
          end
        end
        hit = 0;
        id = 0;
        for (int e = 0; e < n_keys && !hit; e++) begin
          if (key_len[e] == n) begin
            hit = 1;
            for (int i = 0; i < n; i++) if (keys[e][i] != key[i]) hit = 0;
            if (hit) id = e;
          end
        end
        if (!hit) begin
          if (n_keys >= TABLE_DEPTH) begin
            r.status = csi_pkg::ST_FULL;
          end else begin
            id = n_keys;
            for (int i = 0; i < n; i++) keys[id][i] = key[i];
            key_len[id] = n;
            n_keys++;
            r.was_new = 1'b1;
          end
        end
        if (r.status == csi_pkg::ST_OK) r.hull_id = id[5:0];
      end
      pending.delete();
      too_long = 1'b0;
      awaited = {awaited, r};
    endfunction

    function void check_result(logic [5:0] id, logic was_new, logic [1:0] st);
      hull_result_t r;
      n_results++;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: id %0d status %0d", id, st);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (id !== r.hull_id) begin
        $error("hull_id: expected %0d, actual %0d", r.hull_id, id);
        errors++;
      end
      if (was_new !== r.was_new) begin
        $error("was_new: expected %0d, actual %0d", r.was_new, was_new);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_vertex = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_hull_id;
  logic out_was_new;
  logic [1:0] out_status;

  hull_scoreboard sb = new();
  int cycles = 0;
  int n_items = 0;
  bit hold_off = 0;
  logic [7:0] pool[8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cyclic_sequence_interner uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex(in_vertex), .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hull_id(out_hull_id), .out_was_new(out_was_new), .out_status(out_status)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_hull_id, out_was_new, out_status);
  end

  task automatic send_vertex(logic [7:0] v, logic last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex <= v;
    in_last_vertex <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(v, last);
    n_items++;
  endtask

  task automatic send_list(int n, int mode, bit gaps);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = 8'($urandom_range(0, 255));
        1: v = pool[$urandom_range(0, 7)];
        default: v = 8'(i);
      endcase
      if (i != n - 1) send_vertex(v, 1'b0, gaps);
      else send_vertex(v, 1'b1, gaps);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_fixed(logic [7:0] l[$]);
    foreach (l[i]) send_vertex(l[i], i == l.size() - 1, 0);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall per beat, plus one long hold-off when asked.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      stall = (n_items > 380 && n_items < 450) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_fixed({8'd5, 8'd1, 8'd9, 8'd3});
    send_fixed({8'd3, 8'd5, 8'd1, 8'd9});
    send_fixed({8'd1, 8'd3, 8'd9, 8'd5});
    send_fixed({8'd7});
    send_fixed({8'd0, 8'd255});
    send_fixed({8'd255, 8'd0, 8'd255});
    send_fixed({8'd2, 8'd2, 8'd2});
    send_list(17, 2, 0);
    send_list(16, 2, 0);
    send_list(16, 0, 0);
    for (int i = 0; i < 8; i++) pool[i] = 8'($urandom_range(0, 255));
    pool[0] = 8'h00;
    pool[1] = 8'hff;
    hold_off = 1;
    for (int k = 0; k < 8; k++) send_list($urandom_range(3, 5), 1, 0);
    wait_drained();
    repeat (50) @(posedge clk);
    while (n_items < 520) begin
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 8) n = $urandom_range(1, 2);
      else if (r < 14) n = $urandom_range(17, 20);
      else n = $urandom_range(3, 6);
      send_list(n, r < 60 ? 1 : 0, $urandom_range(0, 3) != 0);
    end
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered %0d vertices and %0d results; table held %0d keys at the end.",
             n_items, sb.n_results, sb.n_keys);
    $display("Lists included short, long, rotated, reversed and table-full cases.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
